// ----- hw/rtl/btpl_pkg.sv -----
// Shared constants and types for the binary trie prefix lookup core.
package btpl_pkg;

   localparam int NODE_COUNT    = 4096;
   localparam int ADDRESS_BITS  = 32;
   localparam int HOP_BITS      = 16;
   localparam int NODE_IDX_BITS = $clog2(NODE_COUNT);
   localparam int COUNT_BITS    = $clog2(NODE_COUNT + 1);
   localparam int LEVEL_BITS    = $clog2(ADDRESS_BITS + 1);

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_LOOKUP = 1'b1
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic [NODE_IDX_BITS-1:0] child_zero;
      logic [NODE_IDX_BITS-1:0] child_one;
      logic                     hop_valid;
      logic [HOP_BITS-1:0]      hop_value;
   } node_rec_type;

endpackage

// ----- hw/rtl/binary_trie_prefix_lookup_core.sv -----
// Operation: after a request transfer the walk takes one step per trie level visited and a
// final step; an insert walks plen levels unless the table fills, a lookup at most 32.
// Throughput: one item at a time, as the node memory is stepped once per level; the last
// step waits while a result is held. Reset: the root node clears and the node counter is set
// to one, for the root, at once; other nodes are initialized on allocation, so there is no
// clearing pass and requests are taken right after reset.
module binary_trie_prefix_lookup_core
   import btpl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [31:0] req_ip_address,
   input  logic [5:0]  req_prefix_length,
   input  logic [15:0] req_next_hop_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hop_found,
   output logic [15:0] rsp_matched_hop,
   output logic        rsp_table_full
);

   state_type                state_ff, state_in;
   cmd_type                  cmd_ff;
   logic [ADDRESS_BITS-1:0]  addr_ff;
   logic [LEVEL_BITS-1:0]    plen_ff;
   logic [HOP_BITS-1:0]      hop_ff;
   logic [LEVEL_BITS-1:0]    level_ff;
   logic [NODE_IDX_BITS-1:0] cur_ff;
   logic                     fresh_ff;
   logic [COUNT_BITS-1:0]    nodes_used_ff;
   logic                     best_found_ff;
   logic [HOP_BITS-1:0]      best_hop_ff;
   node_rec_type             root_rec_ff;
   node_rec_type             rd_rec_ff;
   node_rec_type             node_mem_ff [NODE_COUNT];
   logic                     rsp_valid_ff;
   logic                     rsp_hop_found_ff;
   logic [15:0]              rsp_matched_hop_ff;
   logic                     rsp_table_full_ff;

   node_rec_type             cur_rec;
   logic                     walk_bit;
   logic [NODE_IDX_BITS-1:0] child;
   logic                     child_null;
   logic                     pool_full;
   logic                     at_end;
   logic                     finish;
   logic                     slot_free;
   logic                     step;
   logic                     req_xfer;
   logic                     look_found;
   logic [HOP_BITS-1:0]      look_hop;
   logic [LEVEL_BITS-1:0]    plen_sat;

   // Step controls.
   logic                     done;
   logic                     advance;
   logic                     alloc;
   logic                     mem_we;
   logic                     root_we;
   logic                     rd_en;
   node_rec_type             wr_rec;
   logic [NODE_IDX_BITS-1:0] new_idx;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;

   assign plen_sat = (req_prefix_length > 6'(ADDRESS_BITS)) ? LEVEL_BITS'(ADDRESS_BITS)
                                                           : LEVEL_BITS'(req_prefix_length);

   // A freshly allocated node has not been read back from memory; its record is known empty.
   always_comb begin
      if (fresh_ff) begin
         cur_rec = '0;
      end else if (cur_ff == '0) begin
         cur_rec = root_rec_ff;
      end else begin
         cur_rec = rd_rec_ff;
      end
   end

   assign walk_bit   = addr_ff[ADDRESS_BITS-1];
   assign child      = walk_bit ? cur_rec.child_one : cur_rec.child_zero;
   assign child_null = (child == '0);
   assign pool_full  = (nodes_used_ff == COUNT_BITS'(NODE_COUNT));
   assign new_idx    = nodes_used_ff[NODE_IDX_BITS-1:0];
   assign at_end     = (cmd_ff == CMD_LOOKUP) ? (level_ff == LEVEL_BITS'(ADDRESS_BITS))
                                              : (level_ff == plen_ff);
   assign look_found = best_found_ff | cur_rec.hop_valid;
   assign look_hop   = cur_rec.hop_valid ? cur_rec.hop_value : best_hop_ff;

   always_comb begin
      if (cmd_ff == CMD_LOOKUP) begin
         finish = at_end || child_null;
      end else begin
         finish = at_end || (child_null && pool_full);
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign step      = (state_ff == ST_WALK) && (!finish || slot_free);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (step && finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Controls of one walk step. The current node is written back when it gains a child,
   // and at the end of an insert, which also initializes a node allocated last.
   always_comb begin
      done    = 1'b0;
      advance = 1'b0;
      alloc   = 1'b0;
      rd_en   = 1'b0;
      mem_we  = 1'b0;
      root_we = 1'b0;
      wr_rec  = cur_rec;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_WALK: begin
            if (step) begin
               if (finish) begin
                  done = 1'b1;
                  if (cmd_ff == CMD_INSERT) begin
                     if (at_end) begin
                        wr_rec.hop_valid = 1'b1;
                        wr_rec.hop_value = hop_ff;
                     end
                     root_we = (cur_ff == '0);
                     mem_we  = (cur_ff != '0);
                  end
               end else begin
                  advance = 1'b1;
                  if (child_null) begin
                     alloc = 1'b1;
                     if (walk_bit) begin
                        wr_rec.child_one = new_idx;
                     end else begin
                        wr_rec.child_zero = new_idx;
                     end
                     root_we = (cur_ff == '0);
                     mem_we  = (cur_ff != '0);
                  end else begin
                     rd_en = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem_ff[cur_ff] <= wr_rec;
      end
      if (rd_en) begin
         rd_rec_ff <= node_mem_ff[child];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         nodes_used_ff <= COUNT_BITS'(1);
         root_rec_ff   <= '0;
         fresh_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (root_we) begin
            root_rec_ff <= wr_rec;
         end
         if (alloc) begin
            nodes_used_ff <= nodes_used_ff + COUNT_BITS'(1);
         end
         if (req_xfer) begin
            fresh_ff <= 1'b0;
         end else if (advance) begin
            fresh_ff <= alloc;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff        <= cmd_type'(req_command);
         addr_ff       <= req_ip_address[ADDRESS_BITS-1:0];
         plen_ff       <= plen_sat;
         hop_ff        <= HOP_BITS'(req_next_hop_id);
         level_ff      <= '0;
         cur_ff        <= '0;
         best_found_ff <= 1'b0;
         best_hop_ff   <= '0;
      end else if (advance) begin
         addr_ff       <= addr_ff << 1;
         level_ff      <= level_ff + LEVEL_BITS'(1);
         cur_ff        <= alloc ? new_idx : child;
         best_found_ff <= look_found;
         best_hop_ff   <= look_hop;
      end
      if (done) begin
         if (cmd_ff == CMD_LOOKUP) begin
            rsp_hop_found_ff   <= look_found;
            rsp_matched_hop_ff <= 16'(look_hop);
            rsp_table_full_ff  <= 1'b0;
         end else begin
            rsp_hop_found_ff   <= 1'b0;
            rsp_matched_hop_ff <= '0;
            rsp_table_full_ff  <= !at_end;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hop_found   = rsp_hop_found_ff;
   assign rsp_matched_hop = rsp_matched_hop_ff;
   assign rsp_table_full  = rsp_table_full_ff;

`ifndef SYNTHESIS
   a_nodes_in_range: assert property (@(posedge clock) disable iff (reset)
      (nodes_used_ff != '0) && (nodes_used_ff <= COUNT_BITS'(NODE_COUNT)))
      else $error("node counter out of range");

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && root_we))
      else $error("root register and node memory written together");

   a_no_root_in_mem: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (cur_ff != '0))
      else $error("node memory written at the root index");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("request taken while a walk should be running");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (level_ff <= LEVEL_BITS'(ADDRESS_BITS)))
      else $error("walk passed the last address bit");
`endif

endmodule
